[rtl/mdlp_pkg.sv]
// Shared types and constants of the minimum-degree layer peeling block.
package mdlp_pkg;

	localparam int MAX_NODES  = 64;
	localparam int NODE_LIMIT = (MAX_NODES < 64) ? MAX_NODES : 64;
	localparam int ID_W       = 6;
	localparam int DEG_W      = 7;

	localparam logic KIND_EDGE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic CFG_NODE_COUNT = 1'b0;
	localparam logic CFG_DIRECTED   = 1'b1;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] source_node;
		logic [ID_W-1:0] target_node;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0] layer_rank;
		logic [ID_W-1:0] node_id;
		logic            last;
	} result_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_INIT,
		OP_DEG,
		OP_ROT,
		OP_PEEL,
		OP_WIPE
	} cell_op_t;

	typedef struct packed {
		logic [NODE_LIMIT-1:0] row;
		logic                  removed;
		logic [DEG_W-1:0]      deg;
		logic [ID_W-1:0]       rnd;
	} cell_data_t;

	typedef struct packed {
		cell_op_t         op;
		logic             dir;
		logic             head_alive;
		logic [DEG_W-1:0] min_deg;
		logic [ID_W-1:0]  rnd;
	} cell_ctrl_t;

endpackage

[rtl/mdlp_cell.sv]
// One node cell of the peeling ring: adjacency row, removed flag, degree and round.
module mdlp_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mdlp_pkg::cell_ctrl_t           ctrl,
	input  mdlp_pkg::cell_data_t           nb,
	input  logic                           head_bit,
	input  logic                           init_removed,
	input  logic [mdlp_pkg::NODE_LIMIT-1:0] load_mask,
	output mdlp_pkg::cell_data_t           cur,
	output mdlp_pkg::cell_data_t           fwd
);

	logic [mdlp_pkg::NODE_LIMIT-1:0] row_q;
	logic                            removed_q;
	logic [mdlp_pkg::DEG_W-1:0]      deg_q;
	logic [mdlp_pkg::ID_W-1:0]       rnd_q;
	logic                            inc;

	assign cur = '{row: row_q, removed: removed_q, deg: deg_q, rnd: rnd_q};
	assign inc = ctrl.head_alive & (ctrl.dir ? head_bit : row_q[0]);

	// During a degree step the row also turns by one bit so bit 0 tracks the head node.
	always_comb begin
		fwd = cur;
		if (ctrl.op == mdlp_pkg::OP_DEG) begin
			fwd.row = {row_q[0], row_q[mdlp_pkg::NODE_LIMIT-1:1]};
			fwd.deg = deg_q + {{(mdlp_pkg::DEG_W-1){1'b0}}, inc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else begin
			case (ctrl.op)
				mdlp_pkg::OP_LOAD: row_q <= row_q | load_mask;
				mdlp_pkg::OP_DEG,
				mdlp_pkg::OP_ROT:  row_q <= nb.row;
				mdlp_pkg::OP_WIPE: row_q <= '0;
				default:           row_q <= row_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			mdlp_pkg::OP_INIT: begin
				removed_q <= init_removed;
				deg_q     <= '0;
			end
			mdlp_pkg::OP_DEG,
			mdlp_pkg::OP_ROT: begin
				removed_q <= nb.removed;
				deg_q     <= nb.deg;
				rnd_q     <= nb.rnd;
			end
			mdlp_pkg::OP_PEEL: begin
				if (!removed_q && deg_q == ctrl.min_deg) begin
					removed_q <= 1'b1;
					rnd_q     <= ctrl.rnd;
				end
				deg_q <= '0;
			end
			default: begin
				removed_q <= removed_q;
			end
		endcase
	end

endmodule

[rtl/min_degree_layer_peeling_top.sv]
// Top level of the minimum-degree layer peeling block: ring of node cells and its sequencer.
// An edge item is written straight into the matrix; busy stays low and the next item may follow at once.
// A finish item peels rounds until no node is left: each round sweeps the 64-cell ring once
// for degrees and once for the minimum, and the report sweeps the ring once per rank.
// Results leave one per strobe and cannot be held off.
// Reset clears the matrix, selects 64 nodes and directed mode; the block is idle at once.
module min_degree_layer_peeling_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  mdlp_pkg::in_item_t   item,
	output logic                 done,
	output mdlp_pkg::result_t    result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [6:0]           cfg_data
);

	localparam int NL = mdlp_pkg::NODE_LIMIT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_CHECK,
		ST_DEG,
		ST_MIN,
		ST_PEEL,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	state_t                     state_q;
	logic [6:0]                 node_count_q;
	logic                       directed_q;
	logic [mdlp_pkg::ID_W-1:0]  cnt_q;
	logic [mdlp_pkg::DEG_W-1:0] min_q;
	logic [6:0]                 round_q;
	logic [mdlp_pkg::ID_W-1:0]  rank_q;
	logic                       pend_valid_q;
	mdlp_pkg::result_t          pend_q;
	logic                       done_q;
	mdlp_pkg::result_t          result_q;

	mdlp_pkg::cell_data_t       cur [NL];
	mdlp_pkg::cell_data_t       fwd [NL];
	logic [NL-1:0]              alive_vec;
	mdlp_pkg::cell_ctrl_t       ctrl;

	logic [6:0]                 n_eff;
	logic                       accept;
	logic                       edge_ok;
	logic                       sweep_end;
	logic [6:0]                 target;
	logic                       head_hit;

	assign n_eff     = (node_count_q > 7'(NL)) ? 7'(NL) : node_count_q;
	assign accept    = start && (state_q == ST_IDLE);
	assign edge_ok   = accept && (item.kind == mdlp_pkg::KIND_EDGE)
	                   && ({1'b0, item.source_node} < n_eff)
	                   && ({1'b0, item.target_node} < n_eff);
	assign sweep_end = (cnt_q == mdlp_pkg::ID_W'(NL - 1));
	assign target    = round_q - 7'd1 - {1'b0, rank_q};
	assign head_hit  = ({1'b0, cnt_q} < n_eff) && (cur[0].rnd == target[mdlp_pkg::ID_W-1:0]);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign done      = done_q;
	assign result    = result_q;

	always_comb begin
		ctrl.dir        = directed_q;
		ctrl.head_alive = !cur[0].removed;
		ctrl.min_deg    = min_q;
		ctrl.rnd        = round_q[mdlp_pkg::ID_W-1:0];
		case (state_q)
			ST_IDLE:  ctrl.op = edge_ok ? mdlp_pkg::OP_LOAD : mdlp_pkg::OP_HOLD;
			ST_INIT:  ctrl.op = mdlp_pkg::OP_INIT;
			ST_DEG:   ctrl.op = mdlp_pkg::OP_DEG;
			ST_MIN:   ctrl.op = mdlp_pkg::OP_ROT;
			ST_PEEL:  ctrl.op = mdlp_pkg::OP_PEEL;
			ST_EMIT:  ctrl.op = mdlp_pkg::OP_ROT;
			ST_FLUSH: ctrl.op = mdlp_pkg::OP_WIPE;
			default:  ctrl.op = mdlp_pkg::OP_HOLD;
		endcase
	end

	for (genvar p = 0; p < NL; p++) begin : g_cell
		logic [NL-1:0] load_mask;

		always_comb begin
			load_mask = '0;
			if (edge_ok && item.source_node == mdlp_pkg::ID_W'(p))
				load_mask = load_mask | (NL'(1) << item.target_node);
			if (edge_ok && !directed_q && item.target_node == mdlp_pkg::ID_W'(p))
				load_mask = load_mask | (NL'(1) << item.source_node);
		end

		mdlp_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.nb           (fwd[(p + 1) % NL]),
			.head_bit     (cur[0].row[p]),
			.init_removed (n_eff <= 7'(p)),
			.load_mask    (load_mask),
			.cur          (cur[p]),
			.fwd          (fwd[p])
		);

		assign alive_vec[p] = !cur[p].removed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= 7'd64;
			directed_q   <= 1'b1;
			cnt_q        <= '0;
			min_q        <= '1;
			round_q      <= '0;
			rank_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mdlp_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data;
					mdlp_pkg::CFG_DIRECTED:   directed_q   <= cfg_data[0];
					default:                  directed_q   <= directed_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && item.kind == mdlp_pkg::KIND_FINISH)
						state_q <= ST_INIT;
				end
				ST_INIT: begin
					round_q <= '0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q        <= '0;
					rank_q       <= '0;
					pend_valid_q <= 1'b0;
					if (|alive_vec)
						state_q <= ST_DEG;
					else if (round_q == 7'd0)
						state_q <= ST_FLUSH;
					else
						state_q <= ST_EMIT;
				end
				ST_DEG: begin
					cnt_q <= cnt_q + 1'b1;
					min_q <= '1;
					if (sweep_end)
						state_q <= ST_MIN;
				end
				ST_MIN: begin
					cnt_q <= cnt_q + 1'b1;
					if (!cur[0].removed && cur[0].deg < min_q)
						min_q <= cur[0].deg;
					if (sweep_end)
						state_q <= ST_PEEL;
				end
				ST_PEEL: begin
					round_q <= round_q + 7'd1;
					state_q <= ST_CHECK;
				end
				ST_EMIT: begin
					cnt_q <= cnt_q + 1'b1;
					// hold each hit until the next one so the final one can carry last
					if (head_hit) begin
						pend_valid_q <= 1'b1;
						pend_q       <= '{layer_rank: rank_q, node_id: cnt_q, last: 1'b0};
						if (pend_valid_q) begin
							done_q   <= 1'b1;
							result_q <= pend_q;
						end
					end
					if (sweep_end) begin
						if ({1'b0, rank_q} + 7'd1 == round_q)
							state_q <= ST_FLUSH;
						else
							rank_q <= rank_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (pend_valid_q) begin
						done_q   <= 1'b1;
						result_q <= '{layer_rank: pend_q.layer_rank, node_id: pend_q.node_id,
						              last: 1'b1};
					end
					pend_valid_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last |=> !done)
		else $error("result strobe follows the last result");

	a_edge_quick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == mdlp_pkg::KIND_EDGE |=> !busy && !done)
		else $error("edge item did not complete in one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a running finish item");

endmodule
